### hw/rtl/ttd_pkg.sv
// Shared types and constants for the turn-then-drive motion controller.
package ttd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_HEADING = 3'd0,
        REG_TARGET_TRAVEL  = 3'd1,
        REG_TURN_LIMIT     = 3'd2,
        REG_DRIVE_SPEED    = 3'd3,
        REG_MIN_TURN       = 3'd4,
        REG_ANGLE_TOL      = 3'd5,
        REG_DIST_TOL       = 3'd6,
        REG_GAIN           = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_RUNNING   = 3'd1,
        ST_SUCCEEDED = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_REJECTED  = 3'd4
    } status_t;

    localparam logic [0:0] OP_START = 1'b0;

    // Controller phase kept across beats
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TURN   = 3'd1,
        PH_SETTLE = 3'd2,
        PH_DRIVE  = 3'd3,
        PH_FINAL  = 3'd4
    } phase_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic latch_in;   // capture the input beat
        logic sqrt_start; // begin the distance root
        logic sqrt_step;  // one root iteration
        logic mul_run;    // form gain times error
        logic finish;     // compute the result and update the state
        logic out_load;   // load the output register
    } dp_cmd_t;

    typedef struct packed {
        logic sqrt_done;
    } dp_status_t;

    typedef struct packed {
        logic signed [15:0] target_heading;
        logic signed [31:0] target_travel;
        logic [14:0]        turn_speed_limit;
        logic [14:0]        drive_speed;
        logic [14:0]        min_turn_speed;
        logic [14:0]        angle_tolerance;
        logic [30:0]        distance_tolerance;
        logic [15:0]        gain;
    } cfg_t;

    // Register values after reset
    localparam cfg_t CFG_RESET = '{
        target_heading:     16'sd0,
        target_travel:      32'sd0,
        turn_speed_limit:   15'd0,
        drive_speed:        15'd0,
        min_turn_speed:     15'd2048,
        angle_tolerance:    15'd71,
        distance_tolerance: 31'd655,
        gain:               16'd1280
    };

    typedef struct packed {
        logic               op;
        logic signed [14:0] yaw;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               cancel;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] turn_command;
        logic signed [15:0] drive_command;
        logic [2:0]         status;
        logic signed [15:0] turned_angle;
        logic [30:0]        travelled;
    } out_beat_t;

endpackage

### hw/rtl/ttd_if.sv
// Valid/ready channel interfaces for input and result beats.
interface ttd_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [14:0] yaw;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               cancel;

    modport source (output valid, op, yaw, pos_x, pos_y, cancel, input ready);
    modport sink (input valid, op, yaw, pos_x, pos_y, cancel, output ready);
endinterface

interface ttd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] turn_command;
    logic signed [15:0] drive_command;
    logic [2:0]         status;
    logic signed [15:0] turned_angle;
    logic [30:0]        travelled;

    modport source (output valid, turn_command, drive_command, status, turned_angle,
                    travelled, input ready);
    modport sink (input valid, turn_command, drive_command, status, turned_angle,
                  travelled, output ready);
endinterface

### hw/rtl/turn_then_drive_motion_controller_unit.sv
// Top level of the turn-then-drive motion controller.
// Flow: an accepted beat passes through the multiply, the bit-at-a-time distance root
// (32 iterations), the finish and the load steps before its result beat appears.
// The next beat is accepted only after the result has left the output, so a stalled
// result holds off the next beat for as long as it waits.
// Reset: asynchronous active-low rst_n clears phase, state and configuration registers to defaults.
module turn_then_drive_motion_controller_unit #(
    parameter int SETTLE_SAMPLES      = 5,
    parameter int ANGLE_FRACTION_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0]  cfg_data,
    ttd_in_if.sink                          in_ch,
    ttd_out_if.source                       out_ch
);

    ttd_pkg::cfg_t       cfg_reg;
    ttd_pkg::dp_cmd_t    cmd;
    ttd_pkg::dp_status_t stat;
    ttd_pkg::in_beat_t   in_beat;
    ttd_pkg::out_beat_t  out_beat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ttd_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (ttd_pkg::cfg_index_t'(cfg_index))
                ttd_pkg::REG_TARGET_HEADING: cfg_reg.target_heading <= cfg_data[15:0];
                ttd_pkg::REG_TARGET_TRAVEL:  cfg_reg.target_travel  <= cfg_data;
                ttd_pkg::REG_TURN_LIMIT:  cfg_reg.turn_speed_limit   <= cfg_data[14:0];
                ttd_pkg::REG_DRIVE_SPEED: cfg_reg.drive_speed        <= cfg_data[14:0];
                ttd_pkg::REG_MIN_TURN:    cfg_reg.min_turn_speed     <= cfg_data[14:0];
                ttd_pkg::REG_ANGLE_TOL:   cfg_reg.angle_tolerance    <= cfg_data[14:0];
                ttd_pkg::REG_DIST_TOL:    cfg_reg.distance_tolerance <= cfg_data[30:0];
                ttd_pkg::REG_GAIN:        cfg_reg.gain               <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign in_beat.op     = in_ch.op;
    assign in_beat.yaw    = in_ch.yaw;
    assign in_beat.pos_x  = in_ch.pos_x;
    assign in_beat.pos_y  = in_ch.pos_y;
    assign in_beat.cancel = in_ch.cancel;

    ttd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ttd_datapath #(
        .SETTLE_SAMPLES      (SETTLE_SAMPLES),
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_beat  (in_beat),
        .cmd      (cmd),
        .stat     (stat),
        .out_beat (out_beat)
    );

    assign out_ch.turn_command  = out_beat.turn_command;
    assign out_ch.drive_command = out_beat.drive_command;
    assign out_ch.status        = out_beat.status;
    assign out_ch.turned_angle  = out_beat.turned_angle;
    assign out_ch.travelled     = out_beat.travelled;

endmodule

### hw/rtl/ttd_ctrl.sv
// Sequencer: accepts a beat, runs the multiply and root, finishes and loads the result.
module ttd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ttd_pkg::dp_cmd_t    cmd,
    input  ttd_pkg::dp_status_t stat
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ROOT = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // accept a new beat only once the previous result has left the output
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_run    = 1'b1;
                cmd.sqrt_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/ttd_datapath.sv
// Datapath: heading accumulation, gain multiply, distance root, result.
module ttd_datapath #(
    parameter int SETTLE_SAMPLES      = 5,
    parameter int ANGLE_FRACTION_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ttd_pkg::cfg_t        cfg,
    input  ttd_pkg::in_beat_t    in_beat,
    input  ttd_pkg::dp_cmd_t     cmd,
    output ttd_pkg::dp_status_t  stat,
    output ttd_pkg::out_beat_t   out_beat
);

    localparam int SC_W = $clog2(SETTLE_SAMPLES + 1);
    // pi and 2*pi rounded to the angle format from a Q28 value
    localparam longint PI_Q28   = 843314857;
    localparam longint TPI_Q28  = 1686629713;
    localparam int     SH       = 28 - ANGLE_FRACTION_BITS;
    localparam longint PI_V     = (PI_Q28 + (64'sd1 <<< (SH - 1))) >>> SH;
    localparam longint TPI_V    = (TPI_Q28 + (64'sd1 <<< (SH - 1))) >>> SH;
    localparam logic signed [17:0] PI_C  = 18'(PI_V);
    localparam logic signed [17:0] TPI_C = 18'(TPI_V);

    // persistent state
    ttd_pkg::phase_t    phase_reg, phase_next;
    logic signed [15:0] turn_total_reg, turn_total_next;
    logic signed [15:0] prev_yaw_reg, prev_yaw_next;
    logic [SC_W-1:0]    settle_reg, settle_next;
    logic signed [31:0] start_x_reg, start_y_reg;
    logic signed [31:0] start_x_next, start_y_next;
    logic [30:0]        dist_done_reg, dist_done_next;

    // working registers
    ttd_pkg::in_beat_t  beat_reg;
    logic signed [15:0] new_total_reg;
    logic signed [16:0] err_reg;
    logic signed [33:0] prod_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        res_reg;
    logic [63:0]        bit_reg;
    logic               dist_sat_reg;
    ttd_pkg::out_beat_t result_reg, result_next, out_reg;

    // wrapped heading change and saturated total
    logic signed [17:0] d_raw, d_wr, tsum;
    logic signed [15:0] new_total;
    always_comb
    begin
        d_raw = 18'(beat_reg.yaw) - 18'(prev_yaw_reg);
        if (d_raw > PI_C)
            d_wr = d_raw - TPI_C;
        else if (d_raw < -PI_C)
            d_wr = d_raw + TPI_C;
        else
            d_wr = d_raw;
        tsum = 18'(turn_total_reg) + d_wr;
        if (tsum > 18'sd32767)
            new_total = 16'sh7fff;
        else if (tsum < -18'sd32768)
            new_total = 16'sh8000;
        else
            new_total = tsum[15:0];
    end

    // distance deltas for the root
    logic signed [32:0] dx, dy;
    logic [32:0]        ax, ay;
    logic [63:0]        ax2, ay2;
    assign dx  = 33'(beat_reg.pos_x) - 33'(start_x_reg);
    assign dy  = 33'(beat_reg.pos_y) - 33'(start_y_reg);
    assign ax  = dx[32] ? 33'(-dx) : 33'(dx);
    assign ay  = dy[32] ? 33'(-dy) : 33'(dy);
    assign ax2 = 64'(ax[30:0]) * 64'(ax[30:0]);
    assign ay2 = 64'(ay[30:0]) * 64'(ay[30:0]);

    assign stat.sqrt_done = (bit_reg == 64'd0);

    // root iteration, one result bit per cycle
    logic [63:0] trial;
    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            beat_reg <= in_beat;
        end
        if (cmd.mul_run)
        begin
            new_total_reg <= new_total;
            err_reg       <= 17'(cfg.target_heading) - 17'(new_total);
            prod_reg      <= 34'($signed({1'b0, cfg.gain})) *
                             34'(17'(cfg.target_heading) - 17'(new_total));
        end
        if (cmd.sqrt_start)
        begin
            // squares are formed combinationally and captured here, then the root runs
            dist_sat_reg <= ax[32] || ax[31] || ay[32] || ay[31];
            rem_reg      <= ax2 + ay2;
            res_reg      <= '0;
            bit_reg      <= 64'd1 << 62;
        end
        else if (cmd.sqrt_step && bit_reg != 64'd0)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.out_load)
        begin
            out_reg <= result_reg;
        end
    end

    assign out_beat = out_reg;

    // rate command from the registered product
    logic signed [33:0] pr, rnd;
    logic signed [33:0] cmd_v;
    logic signed [33:0] lim, mn;
    logic [16:0]        aerr;
    logic               settled;
    always_comb
    begin
        pr  = prod_reg + 34'sd128;
        rnd = pr >>> 8;
        lim = 34'($signed({1'b0, cfg.turn_speed_limit}));
        mn  = 34'($signed({1'b0, cfg.min_turn_speed}));
        cmd_v = rnd;
        if (cmd_v > lim)
            cmd_v = lim;
        else if (cmd_v < -lim)
            cmd_v = -lim;
        if (cmd_v > 0 && cmd_v < mn)
            cmd_v = mn;
        else if (cmd_v < 0 && cmd_v > -mn)
            cmd_v = -mn;
        aerr    = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
        settled = aerr < 17'(cfg.angle_tolerance);
    end

    logic [30:0] root_dist;
    assign root_dist = (dist_sat_reg || res_reg[63:31] != '0) ? 31'h7fffffff
                                                               : res_reg[30:0];

    // goal distance figures
    logic [32:0] agoal;
    logic signed [15:0] dspeed;
    assign agoal  = cfg.target_travel[31] ? 33'(-33'(cfg.target_travel))
                                          : 33'(cfg.target_travel);
    assign dspeed = (cfg.target_travel > 0) ? 16'($signed({1'b0, cfg.drive_speed}))
                                            : -16'($signed({1'b0, cfg.drive_speed}));

    // result and next state
    always_comb
    begin
        phase_next      = phase_reg;
        turn_total_next = turn_total_reg;
        prev_yaw_next   = prev_yaw_reg;
        settle_next     = settle_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        dist_done_next  = dist_done_reg;
        result_next     = result_reg;
        if (cmd.finish)
        begin
            result_next        = '0;
            result_next.status = ttd_pkg::ST_RUNNING;
            if (beat_reg.op == ttd_pkg::OP_START)
            begin
                turn_total_next = '0;
                dist_done_next  = '0;
                settle_next     = '0;
                if (cfg.turn_speed_limit == '0 || cfg.drive_speed == '0)
                begin
                    phase_next         = ttd_pkg::PH_IDLE;
                    result_next.status = ttd_pkg::ST_REJECTED;
                end
                else
                begin
                    prev_yaw_next = 16'(beat_reg.yaw);
                    phase_next    = (cfg.target_heading != '0) ? ttd_pkg::PH_TURN
                                                               : ttd_pkg::PH_SETTLE;
                end
            end
            else
            begin
                case (phase_reg)
                    ttd_pkg::PH_TURN:
                    begin
                        turn_total_next          = new_total_reg;
                        prev_yaw_next            = 16'(beat_reg.yaw);
                        result_next.turned_angle = new_total_reg;
                        if (settled && 32'(settle_reg) + 1 >= SETTLE_SAMPLES)
                        begin
                            settle_next = '0;
                            phase_next  = ttd_pkg::PH_SETTLE;
                        end
                        else
                        begin
                            settle_next = settled ? settle_reg + 1'b1 : '0;
                            if (beat_reg.cancel)
                            begin
                                phase_next               = ttd_pkg::PH_IDLE;
                                result_next.status       = ttd_pkg::ST_CANCELLED;
                                result_next.turned_angle = turn_total_reg;
                            end
                            else if (!settled)
                            begin
                                result_next.turn_command = cmd_v[15:0];
                            end
                        end
                    end
                    ttd_pkg::PH_SETTLE:
                    begin
                        turn_total_next          = new_total_reg;
                        prev_yaw_next            = 16'(beat_reg.yaw);
                        result_next.turned_angle = new_total_reg;
                        if (cfg.target_travel == '0)
                        begin
                            phase_next         = ttd_pkg::PH_IDLE;
                            result_next.status = ttd_pkg::ST_SUCCEEDED;
                        end
                        else
                        begin
                            start_x_next = beat_reg.pos_x;
                            start_y_next = beat_reg.pos_y;
                            if (33'(cfg.distance_tolerance) >= agoal)
                                phase_next = ttd_pkg::PH_FINAL;
                            else
                            begin
                                phase_next                = ttd_pkg::PH_DRIVE;
                                result_next.drive_command = dspeed;
                            end
                        end
                    end
                    ttd_pkg::PH_DRIVE:
                    begin
                        result_next.turned_angle = turn_total_reg;
                        if (beat_reg.cancel)
                        begin
                            phase_next            = ttd_pkg::PH_IDLE;
                            result_next.status    = ttd_pkg::ST_CANCELLED;
                            result_next.travelled = dist_done_reg;
                        end
                        else
                        begin
                            dist_done_next        = root_dist;
                            result_next.travelled = root_dist;
                            if (33'(root_dist) + 33'(cfg.distance_tolerance) >= agoal)
                                phase_next = ttd_pkg::PH_FINAL;
                            else
                                result_next.drive_command = dspeed;
                        end
                    end
                    ttd_pkg::PH_FINAL:
                    begin
                        dist_done_next           = root_dist;
                        phase_next               = ttd_pkg::PH_IDLE;
                        result_next.status       = ttd_pkg::ST_SUCCEEDED;
                        result_next.turned_angle = turn_total_reg;
                        result_next.travelled    = root_dist;
                    end
                    default:
                    begin
                        phase_next               = ttd_pkg::PH_IDLE;
                        result_next.status       = ttd_pkg::ST_IDLE;
                        result_next.turned_angle = turn_total_reg;
                        result_next.travelled    = dist_done_reg;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ttd_pkg::PH_IDLE;
            turn_total_reg <= '0;
            prev_yaw_reg   <= '0;
            settle_reg     <= '0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            dist_done_reg  <= '0;
            result_reg     <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            turn_total_reg <= turn_total_next;
            prev_yaw_reg   <= prev_yaw_next;
            settle_reg     <= settle_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            dist_done_reg  <= dist_done_next;
            result_reg     <= result_next;
        end
    end

endmodule

### hw/rtl/ttd_checker.sv
// Port-level checker for the motion controller, with its bind.
module ttd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [15:0] turn_command,
    input logic [15:0] drive_command
);

    // a result waits while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // no new beat is taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted with a result pending");

    // commands are zero unless running
    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ttd_pkg::ST_RUNNING |->
            turn_command == 16'd0 && drive_command == 16'd0)
        else $error("nonzero command outside running status");

    // an accepted beat produces no result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

    // status code in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ttd_pkg::ST_REJECTED)
        else $error("bad status code");

endmodule

bind turn_then_drive_motion_controller_unit ttd_checker u_ttd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .status        (out_ch.status),
    .turn_command  (out_ch.turn_command),
    .drive_command (out_ch.drive_command)
);

### sim/tb_turn_then_drive_motion_controller_unit.sv
// Testbench for the turn-then-drive motion controller: directed and random beats.
`timescale 1ns / 100ps

module tb_turn_then_drive_motion_controller_unit;

    localparam int SETTLE_N = 5;
    localparam logic signed [15:0] PI_Q12 = 16'sd12868;
    localparam logic signed [15:0] TWO_PI_Q12 = 16'sd25736;
    localparam logic OP_TICK = 1'b1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ttd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ttd_pkg::CFG_DATA_W-1:0] cfg_data;

    ttd_in_if in_ch ();
    ttd_out_if out_ch ();

    turn_then_drive_motion_controller_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor copy of configuration and controller state
    ttd_pkg::cfg_t cfg_shadow;
    ttd_pkg::phase_t ctl_phase;
    logic signed [15:0] ctl_turn_total;
    logic signed [15:0] ctl_prev_yaw;
    int unsigned ctl_settle;
    logic signed [31:0] ctl_start_x;
    logic signed [31:0] ctl_start_y;
    logic [30:0] ctl_dist_done;

    ttd_pkg::out_beat_t expected_beats[$];
    int error_count;
    bit idle_gaps;
    bit out_gaps;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint isqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint dist_from_start(logic signed [31:0] x, logic signed [31:0] y);
        longint dx;
        longint dy;
        longint unsigned ax;
        longint unsigned ay;
        longint r;
        dx = longint'(x) - longint'(ctl_start_x);
        dy = longint'(y) - longint'(ctl_start_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax >= 64'd2147483648 || ay >= 64'd2147483648) return 2147483647;
        r = isqrt(ax * ax + ay * ay);
        if (r > 2147483647) r = 2147483647;
        return r;
    endfunction

    function automatic void accumulate_heading(logic signed [14:0] yaw);
        longint d;
        longint t;
        d = longint'(yaw) - longint'(ctl_prev_yaw);
        if (d > PI_Q12) d -= TWO_PI_Q12;
        else if (d < -longint'(PI_Q12)) d += TWO_PI_Q12;
        t = longint'(ctl_turn_total) + d;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        ctl_turn_total = 16'(t);
        ctl_prev_yaw = 16'(yaw);
    endfunction

    function automatic ttd_pkg::out_beat_t predict_motion(ttd_pkg::in_beat_t b);
        ttd_pkg::out_beat_t r;
        longint gdist;
        longint agoal;
        longint tol;
        longint dspeed;
        longint turn;
        longint drive;
        longint rep_angle;
        longint rep_dist;
        longint prior_total;
        longint err;
        longint cmd;
        longint lim;
        longint mn;
        longint v;
        longint d;
        ttd_pkg::status_t st;
        bit done;
        gdist = longint'(cfg_shadow.target_travel);
        agoal = gdist < 0 ? -gdist : gdist;
        tol = longint'(cfg_shadow.distance_tolerance);
        dspeed = gdist > 0 ? longint'(cfg_shadow.drive_speed) : -longint'(cfg_shadow.drive_speed);
        lim = longint'(cfg_shadow.turn_speed_limit);
        mn = longint'(cfg_shadow.min_turn_speed);
        turn = 0;
        drive = 0;
        st = ttd_pkg::ST_RUNNING;
        rep_angle = 0;
        rep_dist = 0;
        if (b.op == ttd_pkg::OP_START) begin
            ctl_turn_total = '0;
            ctl_dist_done = '0;
            ctl_settle = 0;
            if (cfg_shadow.turn_speed_limit == 0 || cfg_shadow.drive_speed == 0) begin
                ctl_phase = ttd_pkg::PH_IDLE;
                st = ttd_pkg::ST_REJECTED;
            end else begin
                ctl_prev_yaw = 16'(b.yaw);
                ctl_phase = cfg_shadow.target_heading != 0 ? ttd_pkg::PH_TURN
                                                           : ttd_pkg::PH_SETTLE;
            end
        end else if (ctl_phase == ttd_pkg::PH_TURN) begin
            prior_total = ctl_turn_total;
            done = 1'b0;
            accumulate_heading(b.yaw);
            err = longint'(cfg_shadow.target_heading) - longint'(ctl_turn_total);
            v = longint'(cfg_shadow.gain) * err + 128;
            cmd = v >= 0 ? (v >>> 8) : -((-v + 255) >>> 8);
            if (cmd > lim) cmd = lim;
            else if (cmd < -lim) cmd = -lim;
            if (cmd > 0 && cmd < mn) cmd = mn;
            else if (cmd < 0 && cmd > -mn) cmd = -mn;
            if ((err < 0 ? -err : err) < longint'(cfg_shadow.angle_tolerance)) begin
                ctl_settle++;
                if (ctl_settle >= SETTLE_N) begin
                    ctl_settle = 0;
                    done = 1'b1;
                end
                cmd = 0;
            end else begin
                ctl_settle = 0;
            end
            rep_angle = ctl_turn_total;
            if (done) begin
                ctl_phase = ttd_pkg::PH_SETTLE;
            end else if (b.cancel) begin
                ctl_phase = ttd_pkg::PH_IDLE;
                st = ttd_pkg::ST_CANCELLED;
                rep_angle = prior_total;
            end else begin
                turn = cmd;
            end
        end else if (ctl_phase == ttd_pkg::PH_SETTLE) begin
            accumulate_heading(b.yaw);
            rep_angle = ctl_turn_total;
            if (gdist == 0) begin
                ctl_phase = ttd_pkg::PH_IDLE;
                st = ttd_pkg::ST_SUCCEEDED;
            end else begin
                ctl_start_x = b.pos_x;
                ctl_start_y = b.pos_y;
                if (tol >= agoal) begin
                    ctl_phase = ttd_pkg::PH_FINAL;
                end else begin
                    ctl_phase = ttd_pkg::PH_DRIVE;
                    drive = dspeed;
                end
            end
        end else if (ctl_phase == ttd_pkg::PH_DRIVE) begin
            d = dist_from_start(b.pos_x, b.pos_y);
            rep_angle = ctl_turn_total;
            if (b.cancel) begin
                ctl_phase = ttd_pkg::PH_IDLE;
                st = ttd_pkg::ST_CANCELLED;
                rep_dist = ctl_dist_done;
            end else begin
                ctl_dist_done = 31'(d);
                rep_dist = d;
                if (d + tol >= agoal) ctl_phase = ttd_pkg::PH_FINAL;
                else drive = dspeed;
            end
        end else if (ctl_phase == ttd_pkg::PH_FINAL) begin
            ctl_dist_done = 31'(dist_from_start(b.pos_x, b.pos_y));
            ctl_phase = ttd_pkg::PH_IDLE;
            st = ttd_pkg::ST_SUCCEEDED;
            rep_angle = ctl_turn_total;
            rep_dist = ctl_dist_done;
        end else begin
            st = ttd_pkg::ST_IDLE;
            rep_angle = ctl_turn_total;
            rep_dist = ctl_dist_done;
        end
        r.turn_command = turn[15:0];
        r.drive_command = drive[15:0];
        r.status = st;
        r.turned_angle = rep_angle[15:0];
        r.travelled = rep_dist[30:0];
        return r;
    endfunction

    // Result checker with random stalls
    initial begin
        ttd_pkg::out_beat_t exp_beat;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    error_count++;
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (out_ch.turn_command !== exp_beat.turn_command) begin
                        $error("turn_command exp %0d got %0d", exp_beat.turn_command,
                               out_ch.turn_command);
                        error_count++;
                    end
                    if (out_ch.drive_command !== exp_beat.drive_command) begin
                        $error("drive_command exp %0d got %0d", exp_beat.drive_command,
                               out_ch.drive_command);
                        error_count++;
                    end
                    if (out_ch.status !== exp_beat.status) begin
                        $error("status exp %0d got %0d", exp_beat.status, out_ch.status);
                        error_count++;
                    end
                    if (out_ch.turned_angle !== exp_beat.turned_angle) begin
                        $error("turned_angle exp %0d got %0d", exp_beat.turned_angle,
                               out_ch.turned_angle);
                        error_count++;
                    end
                    if (out_ch.travelled !== exp_beat.travelled) begin
                        $error("travelled exp %0d got %0d", exp_beat.travelled,
                               out_ch.travelled);
                        error_count++;
                    end
                end
            end
            if (out_gaps && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(ttd_pkg::cfg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            ttd_pkg::REG_TARGET_HEADING: cfg_shadow.target_heading = value[15:0];
            ttd_pkg::REG_TARGET_TRAVEL:  cfg_shadow.target_travel = value;
            ttd_pkg::REG_TURN_LIMIT:  cfg_shadow.turn_speed_limit = value[14:0];
            ttd_pkg::REG_DRIVE_SPEED: cfg_shadow.drive_speed = value[14:0];
            ttd_pkg::REG_MIN_TURN:    cfg_shadow.min_turn_speed = value[14:0];
            ttd_pkg::REG_ANGLE_TOL:   cfg_shadow.angle_tolerance = value[14:0];
            ttd_pkg::REG_DIST_TOL:    cfg_shadow.distance_tolerance = value[30:0];
            ttd_pkg::REG_GAIN:        cfg_shadow.gain = value[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every result is in, then let the block settle
    task automatic drain;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic send_beat(logic op, logic signed [14:0] yaw, logic signed [31:0] px,
                             logic signed [31:0] py, logic cancel);
        ttd_pkg::in_beat_t b;
        // an idle gap here overlaps the processing of the previous beat, so it costs no throughput
        @(posedge clk);
        if (idle_gaps && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        b.op = op;
        b.yaw = yaw;
        b.pos_x = px;
        b.pos_y = py;
        b.cancel = cancel;
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.yaw <= yaw;
        in_ch.pos_x <= px;
        in_ch.pos_y <= py;
        in_ch.cancel <= cancel;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        expected_beats.push_back(predict_motion(b));
        in_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [14:0] rand_yaw();
        return $urandom_range(0, 2) == 0 ? 15'($urandom) :
               15'($signed($urandom_range(0, 25736)) - 12868);
    endfunction

    task automatic test_directed;
        write_reg(ttd_pkg::REG_TARGET_HEADING, 32'd0);
        send_beat(ttd_pkg::OP_START, 15'sd0, 32'sd0, 32'sd0, 1'b0);   // rejected: zero limits
        send_beat(OP_TICK, 15'sd0, 32'sd0, 32'sd0, 1'b1);             // idle tick
        drain();
        write_reg(ttd_pkg::REG_TURN_LIMIT, 32'h7FFF);
        write_reg(ttd_pkg::REG_DRIVE_SPEED, 32'h7FFF);
        write_reg(ttd_pkg::REG_TARGET_TRAVEL, 32'h8000_0000);
        write_reg(ttd_pkg::REG_TARGET_HEADING, 32'h0000_8000);
        // long turn with yaw extremes, wraps, cancel
        send_beat(ttd_pkg::OP_START, 15'sd12868, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_beat(OP_TICK, -15'sd12868, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sh3FFF, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sh4000, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sd0, 32'sd0, 32'sd0, 1'b1);
        drain();
        // zero goal angle: settle then drive at extreme positions, then cancel
        write_reg(ttd_pkg::REG_TARGET_HEADING, 32'd0);
        send_beat(ttd_pkg::OP_START, 15'sd0, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sd100, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        send_beat(OP_TICK, 15'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_beat(ttd_pkg::OP_START, 15'sd0, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sd0, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sd0, 32'sd5, 32'sd5, 1'b1);
        drain();
        // zero goal distance succeeds at settle; tolerance covers goal
        write_reg(ttd_pkg::REG_TARGET_TRAVEL, 32'd0);
        send_beat(ttd_pkg::OP_START, 15'sd0, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sd0, 32'sd0, 32'sd0, 1'b0);
        drain();
        write_reg(ttd_pkg::REG_TARGET_TRAVEL, 32'd600);
        send_beat(ttd_pkg::OP_START, 15'sd0, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sd0, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sd0, 32'sd300, 32'sd400, 1'b1);
        drain();
        // minimum above limit, large gain
        write_reg(ttd_pkg::REG_MIN_TURN, 32'h7FFF);
        write_reg(ttd_pkg::REG_TURN_LIMIT, 32'd1);
        write_reg(ttd_pkg::REG_GAIN, 32'hFFFF);
        write_reg(ttd_pkg::REG_ANGLE_TOL, 32'd0);
        write_reg(ttd_pkg::REG_DIST_TOL, 32'h7FFF_FFFF);
        write_reg(ttd_pkg::REG_TARGET_HEADING, 32'd500);
        send_beat(ttd_pkg::OP_START, 15'sd0, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sd10, 32'sd0, 32'sd0, 1'b0);
        send_beat(OP_TICK, 15'sd600, 32'sd0, 32'sd0, 1'b0);
        drain();
    endtask

    // Goal runs until n_beats beats are sent: a start, then ticks that mostly head for the goal
    task automatic test_random_goals(int n_beats, bit rand_cfg);
        int sent;
        int ticks;
        int k;
        logic signed [14:0] yaw;
        logic signed [31:0] px;
        logic signed [31:0] py;
        int step;
        sent = 0;
        while (sent < n_beats) begin
            if (rand_cfg) begin
                write_reg(ttd_pkg::REG_TARGET_HEADING, $urandom_range(0, 3) == 0 ? $urandom :
                          32'($signed($urandom_range(0, 2000)) - 1000));
                write_reg(ttd_pkg::REG_TARGET_TRAVEL, $urandom_range(0, 3) == 0 ? $urandom :
                          32'($signed($urandom_range(0, 400000)) - 200000));
                write_reg(ttd_pkg::REG_TURN_LIMIT,
                          $urandom_range(0, 20) == 0 ? 0 : $urandom_range(1, 32767));
                write_reg(ttd_pkg::REG_DRIVE_SPEED, $urandom_range(0, 20) == 0 ? 0 : $urandom);
                write_reg(ttd_pkg::REG_MIN_TURN, $urandom_range(0, 4096));
                write_reg(ttd_pkg::REG_ANGLE_TOL,
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200));
                write_reg(ttd_pkg::REG_DIST_TOL,
                          $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 3000));
                write_reg(ttd_pkg::REG_GAIN,
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000));
            end
            yaw = rand_yaw();
            px = $urandom;
            py = $urandom;
            send_beat(ttd_pkg::OP_START, yaw, px, py, 1'b0);
            sent++;
            ticks = $urandom_range(5, 40);
            for (k = 0; k < ticks; k++) begin
                // mostly follow the commanded direction so the turn can settle
                step = $urandom_range(0, 4) == 0 ? $urandom_range(0, 400) - 200 :
                       (ctl_turn_total < cfg_shadow.target_heading ?
                        $urandom_range(0, 150) : -$urandom_range(0, 150));
                if ($urandom_range(0, 10) == 0) yaw = rand_yaw();
                else if (ctl_phase != ttd_pkg::PH_TURN) yaw = yaw;
                else yaw = 15'(yaw + step);
                if (ctl_phase == ttd_pkg::PH_DRIVE) begin
                    px = px + $signed($urandom_range(0, 60000));
                    py = py + $signed($urandom_range(0, 60000)) - 30000;
                end
                if ($urandom_range(0, 40) == 0) begin
                    px = $urandom;
                    py = $urandom;
                end
                send_beat(OP_TICK, yaw, px, py, $urandom_range(0, 30) == 0);
                sent++;
            end
            if (rand_cfg) drain();
        end
    endtask

    initial begin
        error_count = 0;
        idle_gaps = 1'b0;
        out_gaps = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.op = 1'b0;
        in_ch.yaw = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.cancel = 1'b0;
        cfg_shadow = ttd_pkg::CFG_RESET;
        ctl_phase = ttd_pkg::PH_IDLE;
        ctl_turn_total = '0;
        ctl_prev_yaw = '0;
        ctl_settle = 0;
        ctl_start_x = '0;
        ctl_start_y = '0;
        ctl_dist_done = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        idle_gaps = 1'b1;
        out_gaps = 1'b1;
        test_random_goals(700, 1'b1);
        // defaults-like settings with gaps, then a run with no idling
        write_reg(ttd_pkg::REG_MIN_TURN, 32'd2048);
        write_reg(ttd_pkg::REG_ANGLE_TOL, 32'd71);
        write_reg(ttd_pkg::REG_DIST_TOL, 32'd655);
        write_reg(ttd_pkg::REG_GAIN, 32'd1280);
        write_reg(ttd_pkg::REG_TURN_LIMIT, 32'd8192);
        write_reg(ttd_pkg::REG_DRIVE_SPEED, 32'd1024);
        write_reg(ttd_pkg::REG_TARGET_HEADING, 32'hFFFF_F9C0);
        write_reg(ttd_pkg::REG_TARGET_TRAVEL, 32'd150000);
        test_random_goals(300, 1'b0);
        drain();
        idle_gaps = 1'b0;
        out_gaps = 1'b0;
        test_random_goals(250, 1'b0);
        drain();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
